/* src/chacha20_block_keystream_top_assert.svh */
// Assertion helpers for the checker of this block.
`ifndef CHACHA20_BLOCK_KEYSTREAM_TOP_ASSERT_SVH
`define CHACHA20_BLOCK_KEYSTREAM_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CC20_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cc20 check failed");

// Next-cycle implication, disabled during reset.
`define CC20_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cc20 check failed");

`endif

/* src/cc20_pkg.sv */
package cc20_pkg;

  localparam int WORD_W     = 32;
  localparam int NWORDS     = 16;
  localparam int IDX_W      = 4;
  localparam int LANES      = 4;
  localparam int ROUNDS_DEF = 20;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY01   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY23   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY45   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY67   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE2  = 3'd5;

  localparam logic [WORD_W-1:0] SIGMA0 = 32'h61707865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320646e;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h79622d32;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b206574;

  localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NWORDS-1:0] word_arr_t;
  typedef word_t [LANES-1:0] lane_arr_t;

  // Sequencer outputs that steer the datapath.
  typedef struct packed {
    logic             idle;
    logic             round_en;
    logic [1:0]       step;
    logic             diag;
    logic             emit_en;
    logic [IDX_W-1:0] emit_idx;
    logic             emit_last;
  } ctl_t;

  function automatic word_t rotl(word_t x, int n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic word_arr_t build_init(
    logic [CFG_DATA_W-1:0] k01, logic [CFG_DATA_W-1:0] k23,
    logic [CFG_DATA_W-1:0] k45, logic [CFG_DATA_W-1:0] k67,
    logic [CFG_DATA_W-1:0] n01, word_t n2, word_t ctr);
    word_arr_t s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    s[4]  = k01[31:0];
    s[5]  = k01[63:32];
    s[6]  = k23[31:0];
    s[7]  = k23[63:32];
    s[8]  = k45[31:0];
    s[9]  = k45[63:32];
    s[10] = k67[31:0];
    s[11] = k67[63:32];
    s[12] = ctr;
    s[13] = n01[31:0];
    s[14] = n01[63:32];
    s[15] = n2;
    build_init = s;
  endfunction

endpackage

/* src/cc20_if.sv */
interface cc20_in_if;
  import cc20_pkg::*;
  logic  valid;
  logic  ready;
  word_t block_counter;
  modport source (output valid, output block_counter, input ready);
  modport sink   (input valid, input block_counter, output ready);
endinterface

interface cc20_out_if;
  import cc20_pkg::*;
  logic             valid;
  logic             ready;
  word_t            keystream_word;
  logic [IDX_W-1:0] word_index;
  logic             last_word;
  modport source (output valid, output keystream_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input keystream_word, input word_index,
                  input last_word, output ready);
endinterface

/* src/cc20_qr_step.sv */
// One quarter-round step on four lanes: one add, one xor, one rotate each.
module cc20_qr_step import cc20_pkg::*; (
  input  ctl_t      ctl,
  input  lane_arr_t a_in,
  input  lane_arr_t b_in,
  input  lane_arr_t c_in,
  input  lane_arr_t d_in,
  output lane_arr_t a_out,
  output lane_arr_t b_out,
  output lane_arr_t c_out,
  output lane_arr_t d_out
);

  always_comb begin
    word_t sum;
    word_t mix;
    for (int i = 0; i < LANES; i++) begin
      a_out[i] = a_in[i];
      b_out[i] = b_in[i];
      c_out[i] = c_in[i];
      d_out[i] = d_in[i];
      // Odd steps update c and b, even steps update a and d.
      sum = ctl.step[0] ? (c_in[i] + d_in[i]) : (a_in[i] + b_in[i]);
      mix = ctl.step[0] ? (b_in[i] ^ sum) : (d_in[i] ^ sum);
      case (ctl.step)
        2'd0: begin
          a_out[i] = sum;
          d_out[i] = rotl(mix, 16);
        end
        2'd1: begin
          c_out[i] = sum;
          b_out[i] = rotl(mix, 12);
        end
        2'd2: begin
          a_out[i] = sum;
          d_out[i] = rotl(mix, 8);
        end
        default: begin
          c_out[i] = sum;
          b_out[i] = rotl(mix, 7);
        end
      endcase
    end
  end

endmodule

/* src/cc20_seq.sv */
module cc20_seq import cc20_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic slot_free,
  output ctl_t ctl
);

  localparam int RND_W = $clog2(ROUNDS);
  localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [RND_W-1:0] round_r, round_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [IDX_W-1:0] emit_r, emit_nxt;

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    step_nxt  = step_r;
    emit_nxt  = emit_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_ROUND;
          round_nxt = '0;
          step_nxt  = '0;
        end
      end
      ST_ROUND: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          if (round_r == LAST_RND) begin
            state_nxt = ST_EMIT;
            emit_nxt  = '0;
          end else begin
            round_nxt = round_r + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit_nxt = emit_r + 1'b1;
          if (emit_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= '0;
      step_r  <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      step_r  <= step_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_comb begin
    ctl.idle      = (state_r == ST_IDLE);
    ctl.round_en  = (state_r == ST_ROUND);
    ctl.step      = step_r;
    ctl.diag      = round_r[0];
    ctl.emit_en   = (state_r == ST_EMIT) && slot_free;
    ctl.emit_idx  = emit_r;
    ctl.emit_last = (emit_r == LAST_IDX);
  end

endmodule

/* src/chacha20_block_keystream_top.sv */
// ChaCha20 block keystream generator.
// Configuration: write the key pairs (index 0..3), nonce words 0/1 (index 4)
// and nonce word 2 (index 5) on the cfg_ port while the block is idle; other
// indexes are ignored. Input channel in_ch carries one block counter per item;
// the block takes it only when idle (in_ch.ready high).
// Output channel out_ch returns sixteen items per block: keystream word,
// its word index 0..15 and last_word on index 15.
// Sequence: the accept cycle loads the state, then the rounds run (one
// quarter-round step per cycle on four lanes through the shared step unit),
// then one word is loaded into the output register per cycle in which that
// register is free. A new counter is taken once the last word is loaded,
// even while that word still waits to be taken.
// Receiver stall: the output register holds its word and emission pauses.
// Reset: configuration registers clear to zero, the sequencer returns to
// idle and the output channel goes empty.
module chacha20_block_keystream_top import cc20_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cc20_in_if.sink               in_ch,
  cc20_out_if.source            out_ch
);

  logic [CFG_DATA_W-1:0] key01_r, key23_r, key45_r, key67_r, nonce01_r;
  word_t                 nonce2_r;
  word_t                 counter_r;
  word_arr_t             w_r, w_nxt;
  word_arr_t             init_w;
  logic                  in_accept;
  logic                  slot_free;
  ctl_t                  ctl;

  logic                  out_valid_r, out_valid_nxt;
  word_t                 out_word_r;
  logic [IDX_W-1:0]      out_idx_r;
  logic                  out_last_r;

  lane_arr_t la, lb, lc, ld;
  lane_arr_t qa, qb, qc, qd;
  logic [1:0] bsel [LANES];
  logic [1:0] csel [LANES];
  logic [1:0] dsel [LANES];

  // Hold off the input while in reset.
  assign in_ch.ready = ctl.idle && rst_n;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r   <= '0;
      key23_r   <= '0;
      key45_r   <= '0;
      key67_r   <= '0;
      nonce01_r <= '0;
      nonce2_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY01:   key01_r   <= cfg_data;
        CFG_KEY23:   key23_r   <= cfg_data;
        CFG_KEY45:   key45_r   <= cfg_data;
        CFG_KEY67:   key67_r   <= cfg_data;
        CFG_NONCE01: nonce01_r <= cfg_data;
        CFG_NONCE2:  nonce2_r  <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  cc20_seq #(.ROUNDS(ROUNDS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_accept),
    .slot_free (slot_free),
    .ctl       (ctl)
  );

  // Column rounds take lane i straight down; diagonal rounds skew rows b, c, d.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      bsel[i] = 2'(i) + {1'b0, ctl.diag};
      csel[i] = 2'(i) + {ctl.diag, 1'b0};
      dsel[i] = 2'(i) + {ctl.diag, ctl.diag};
      la[i]   = w_r[{2'b00, 2'(i)}];
      lb[i]   = w_r[{2'b01, bsel[i]}];
      lc[i]   = w_r[{2'b10, csel[i]}];
      ld[i]   = w_r[{2'b11, dsel[i]}];
    end
  end

  cc20_qr_step u_step (
    .ctl   (ctl),
    .a_in  (la),
    .b_in  (lb),
    .c_in  (lc),
    .d_in  (ld),
    .a_out (qa),
    .b_out (qb),
    .c_out (qc),
    .d_out (qd)
  );

  assign init_w = build_init(key01_r, key23_r, key45_r, key67_r, nonce01_r,
                             nonce2_r, counter_r);

  always_comb begin
    w_nxt = w_r;
    if (in_accept) begin
      w_nxt = build_init(key01_r, key23_r, key45_r, key67_r, nonce01_r,
                         nonce2_r, in_ch.block_counter);
    end else if (ctl.round_en) begin
      for (int i = 0; i < LANES; i++) begin
        w_nxt[{2'b00, 2'(i)}] = qa[i];
        w_nxt[{2'b01, bsel[i]}] = qb[i];
        w_nxt[{2'b10, csel[i]}] = qc[i];
        w_nxt[{2'b11, dsel[i]}] = qd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (in_accept) begin
      counter_r <= in_ch.block_counter;
    end
  end

  // Feed-forward add on the way into the output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.emit_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_en) begin
      out_word_r <= w_r[ctl.emit_idx] + init_w[ctl.emit_idx];
      out_idx_r  <= ctl.emit_idx;
      out_last_r <= ctl.emit_last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.keystream_word = out_word_r;
  assign out_ch.word_index     = out_idx_r;
  assign out_ch.last_word      = out_last_r;

endmodule

/* src/cc20_checker.sv */
`include "chacha20_block_keystream_top_assert.svh"

module cc20_checker import cc20_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] word_index,
  input logic             last_word
);

  // Last flag marks exactly the final word of a block.
  `CC20_ASSERT_IMP(a_last_flag, clk, rst_n, out_valid, last_word == (word_index == LAST_IDX))

  // Busy right after taking a counter.
  `CC20_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // Words of a block come back to back in index order once the receiver takes one.
  `CC20_ASSERT_NXT(a_next_word, clk, rst_n, out_valid && out_ready && !last_word,
                   out_valid && (word_index == $past(word_index) + 4'd1))

  // Stalled word holds.
  `CC20_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(word_index) && $stable(last_word))

endmodule

bind chacha20_block_keystream_top cc20_checker u_cc20_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .word_index (out_ch.word_index),
  .last_word  (out_ch.last_word)
);
